[rtl/core/booth_radix2_multiplier_core_defines.svh]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier core - assertion macros
// Shared concurrent assertion forms for the core's checker.
// ----------------------------------------------------------------------------
`ifndef BOOTH_RADIX2_MULTIPLIER_CORE_DEFINES_SVH
`define BOOTH_RADIX2_MULTIPLIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[rtl/core/brm_pkg.sv]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier package
// Operand field width and the Booth recoding of one multiplier bit pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brm_pkg;

	// Width of the operand and product fields on the ports.
	localparam int OPND_W = 32;

	typedef enum logic [1:0] {
		BOOTH_NOP,
		BOOTH_ADD,
		BOOTH_SUB
	} booth_op_t;

	// Recode the current multiplier bit and the bit shifted out before it.
	function automatic booth_op_t booth_decode(input logic low, input logic prev);
		booth_op_t op;
		case ({low, prev})
			2'b10:   op = BOOTH_SUB;
			2'b01:   op = BOOTH_ADD;
			default: op = BOOTH_NOP;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

[rtl/core/brm_cell.sv]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier cell
// One recoding step: add, subtract or keep the accumulator, then shift {acc, q, prev} right.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brm_cell
	import brm_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  logic [WIDTH-1:0] up_acc,
	input  logic [WIDTH-1:0] up_q,
	input  logic             up_prev,
	input  logic [WIDTH-1:0] up_m,
	output logic             dn_valid,
	input  logic             dn_stall,
	output logic [WIDTH-1:0] dn_acc,
	output logic [WIDTH-1:0] dn_q,
	output logic             dn_prev,
	output logic [WIDTH-1:0] dn_m
);

	logic             valid_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] q_q;
	logic             prev_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] sum;
	booth_op_t        op;

	// Hold only when full and the neighbor downstream holds too.
	assign up_stall = valid_q && dn_stall;

	always_comb begin
		op = booth_decode(up_q[0], up_prev);
		case (op)
			BOOTH_ADD: sum = up_acc + up_m;
			BOOTH_SUB: sum = up_acc - up_m;
			default:   sum = up_acc;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall) begin
			acc_q  <= {sum[WIDTH-1], sum[WIDTH-1:1]};
			q_q    <= {sum[0], up_q[WIDTH-1:1]};
			prev_q <= up_q[0];
			m_q    <= up_m;
		end
	end

	assign dn_valid = valid_q;
	assign dn_acc   = acc_q;
	assign dn_q     = q_q;
	assign dn_prev  = prev_q;
	assign dn_m     = m_q;

endmodule

`default_nettype wire

[rtl/core/booth_radix2_multiplier_core.sv]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier core
// Signed WIDTH x WIDTH multiply, low half of the product, as a chain of
// WIDTH Booth step cells.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------
//   in      | in_valid, in_stall | multiplicand[31:0], multiplier[31:0]
//   out     | out_valid,out_stall| product_low[31:0]
//
// Each item walks through WIDTH cells, one Booth step per cell, and one
// item enters every cycle while out_stall is low.
// Reset clears only the valid bit of each cell; payload flops are not reset.
// A stall at the output backs up one cell at a time: empty cells keep
// accepting, so in_stall rises only once every cell holds an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module booth_radix2_multiplier_core
	import brm_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [OPND_W-1:0] multiplicand,
	input  logic signed [OPND_W-1:0] multiplier,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OPND_W-1:0] product_low
);

	// Common width for sign-extending the port fields to WIDTH and back.
	localparam int EXT_W = (WIDTH > OPND_W) ? WIDTH : OPND_W;

	logic [EXT_W-1:0] mcand_ext;
	logic [EXT_W-1:0] mplier_ext;
	logic [EXT_W-1:0] prod_ext;

	// Chain nets: index i feeds cell i, index WIDTH leaves the last cell.
	logic             ch_valid [0:WIDTH];
	logic             ch_stall [0:WIDTH];
	logic [WIDTH-1:0] ch_acc   [0:WIDTH];
	logic [WIDTH-1:0] ch_q     [0:WIDTH];
	logic             ch_prev  [0:WIDTH];
	logic [WIDTH-1:0] ch_m     [0:WIDTH];

	// Sign-extend the operands, then keep the low WIDTH bits.
	assign mcand_ext  = EXT_W'(multiplicand);
	assign mplier_ext = EXT_W'(multiplier);

	// Feed the first cell: accumulator and extra bit start at zero.
	assign ch_valid[0] = in_valid;
	assign in_stall    = ch_stall[0];
	assign ch_acc[0]   = '0;
	assign ch_q[0]     = mplier_ext[WIDTH-1:0];
	assign ch_prev[0]  = 1'b0;
	assign ch_m[0]     = mcand_ext[WIDTH-1:0];

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		brm_cell #(
			.WIDTH (WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[i]),
			.up_stall (ch_stall[i]),
			.up_acc   (ch_acc[i]),
			.up_q     (ch_q[i]),
			.up_prev  (ch_prev[i]),
			.up_m     (ch_m[i]),
			.dn_valid (ch_valid[i+1]),
			.dn_stall (ch_stall[i+1]),
			.dn_acc   (ch_acc[i+1]),
			.dn_q     (ch_q[i+1]),
			.dn_prev  (ch_prev[i+1]),
			.dn_m     (ch_m[i+1])
		);
	end

	// The last cell's registers are the output register. After WIDTH steps
	// the low product half has shifted fully into q; the accumulator, extra
	// bit and multiplicand are dropped here.
	assign out_valid       = ch_valid[WIDTH];
	assign ch_stall[WIDTH] = out_stall;

	// Sign-extend the WIDTH-bit result, then keep the field's 32 bits.
	assign prod_ext    = EXT_W'($signed(ch_q[WIDTH]));
	assign product_low = prod_ext[OPND_W-1:0];

endmodule

`default_nettype wire

[rtl/core/brm_checker.sv]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier checker
// Port-level checks on the core's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "booth_radix2_multiplier_core_defines.svh"

module brm_checker
	import brm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [OPND_W-1:0] multiplicand,
	input logic [OPND_W-1:0] multiplier,
	input logic              out_valid,
	input logic              out_stall,
	input logic [OPND_W-1:0] product_low
);

	// Input backs up only when the output holds a stalled item.
	`BRM_ASSERT_NOW(a_in_stall_needs_out_stall, clk, arst_n, in_stall, out_valid && out_stall)

	// A free output drains the chain, so no input is held off.
	`BRM_ASSERT_NOW(a_free_out_frees_in, clk, arst_n, !out_stall, !in_stall)

	// A stalled result holds its value until taken.
	`BRM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(product_low))

	// A refused input item stays offered with unchanged operands.
	`BRM_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall,
		in_valid && $stable(multiplicand) && $stable(multiplier))

endmodule

bind booth_radix2_multiplier_core brm_checker u_brm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.multiplicand (multiplicand),
	.multiplier   (multiplier),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.product_low  (product_low)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Booth radix-2 multiplier core - self-checking testbench
// Drives signed operand pairs through the valid/stall input channel, predicts
// the wrapped low half of each product, and checks every product that
// leaves the output channel in order, under three patterns of idle gaps and
// output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import brm_pkg::*;

	localparam int PIPE_DEPTH  = 32;      // one Booth step cell per bit
	localparam int CYCLE_LIMIT = 600000;  // several times the slowest legal run
	localparam int RAND_ITEMS  = 1300;

	// Holds the expected products in arrival order and checks each one
	// that the block delivers.
	class product_scoreboard;
		logic [OPND_W-1:0] expected_q[$];
		int unsigned       noted;
		int unsigned       checked;
		int unsigned       errors;

		// Radix-2 Booth walk over the full operand width, keeping the low half.
		static function logic [OPND_W-1:0] booth_product(logic [OPND_W-1:0] mcand,
			logic [OPND_W-1:0] mplier);
			logic [OPND_W-1:0] acc;
			logic [OPND_W-1:0] q;
			logic              prev;
			booth_op_t         op;
			acc  = '0;
			q    = mplier;
			prev = 1'b0;
			for (int i = 0; i < OPND_W; i++) begin
				case ({q[0], prev})
					2'b10:   op = BOOTH_SUB;
					2'b01:   op = BOOTH_ADD;
					default: op = BOOTH_NOP;
				endcase
				if (op == BOOTH_SUB)
					acc = acc - mcand;
				else if (op == BOOTH_ADD)
					acc = acc + mcand;
				prev = q[0];
				// arithmetic shift of {acc, q} right by one
				q   = {acc[0], q[OPND_W-1:1]};
				acc = {acc[OPND_W-1], acc[OPND_W-1:1]};
			end
			return q;
		endfunction

		function void note_operands(logic [OPND_W-1:0] mcand, logic [OPND_W-1:0] mplier);
			expected_q.push_back(booth_product(mcand, mplier));
			noted++;
		endfunction

		function void check_product(logic [OPND_W-1:0] got);
			logic [OPND_W-1:0] want;
			if (expected_q.size() == 0) begin
				$error("product_low: no product expected, got %h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got !== want) begin
				$error("product_low: expected %h, got %h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic signed [OPND_W-1:0] multiplicand = '0;
	logic signed [OPND_W-1:0] multiplier   = '0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic signed [OPND_W-1:0] product_low;

	int unsigned       cycle_count = 0;
	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;
	product_scoreboard sb          = new();

	booth_radix2_multiplier_core #(
		.WIDTH(PIPE_DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.multiplicand(multiplicand),
		.multiplier  (multiplier),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.product_low (product_low)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Receiver: stall at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Watch both handshakes on the values present just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_operands(multiplicand, multiplier);
			if (out_valid && !out_stall)
				sb.check_product(product_low);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d products outstanding",
			cycle_count, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one operand pair, idling first at the sender's rate, and hold it
	// until the block takes it.
	task automatic send_operands(input logic [OPND_W-1:0] mcand,
		input logic [OPND_W-1:0] mplier);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		multiplicand <= mcand;
		multiplier   <= mplier;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding product to drain.
	task automatic drain_products();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Operand mix: half full random, plus small values, extremes, single
	// bits and repeated patterns that give long Booth add/subtract runs.
	function automatic logic [OPND_W-1:0] pick_operand();
		logic [OPND_W-1:0] v;
		logic [7:0]        pat;
		case ($urandom_range(0, 7))
			1: v = OPND_W'($signed($urandom_range(0, 31)) - 16);
			2: begin
				case ($urandom_range(0, 4))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'hFFFF_FFFF;
					3:       v = 32'h0000_0001;
					default: v = 32'h0000_0000;
				endcase
			end
			3: begin
				v = 32'h1 << $urandom_range(0, OPND_W - 1);
				if ($urandom_range(0, 1))
					v = ~v;
			end
			4: begin
				pat = 8'($urandom());
				v   = {4{pat}};
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_operands(pick_operand(), pick_operand());
	endtask

	initial begin
		tx_idle_pct = 27;
		rx_idle_pct = 68;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, wrapping overflow, sign combinations, and
		// patterns that hit every Booth recoding pair.
		send_operands(32'h8000_0000, 32'hFFFF_FFFF);  // most negative times -1 wraps
		send_operands(32'hFFFF_FFFF, 32'h8000_0000);
		send_operands(32'h8000_0000, 32'h8000_0000);
		send_operands(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_operands(32'h7FFF_FFFF, 32'h8000_0000);
		send_operands(32'h8000_0000, 32'h7FFF_FFFF);
		send_operands(32'h0000_0000, 32'hDEAD_BEEF);
		send_operands(32'h1234_5678, 32'h0000_0000);
		send_operands(32'h0000_0001, 32'h8765_4321);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_operands(32'h8000_0000, 32'h0000_0001);
		send_operands(32'h5555_5555, 32'h5555_5555);
		send_operands(32'hAAAA_AAAA, 32'hAAAA_AAAA);
		send_operands(32'h0001_0000, 32'h0001_0000);  // wraps to zero
		send_operands(32'hFFFF_FFFE, 32'h0000_0003);
		send_operands(32'h0000_0007, 32'hFFFF_FFF9);
		send_operands(32'h0F0F_0F0F, 32'hF0F0_F0F0);
		send_operands(32'h0000_FFFF, 32'hFFFF_0000);
		send_operands(32'h0000_0000, 32'h0000_0000);

		// Phase one: sender gaps light, receiver stalls heavy.
		run_random(RAND_ITEMS / 6);
		drain_products();  // sender holds off until every product is back
		run_random(RAND_ITEMS / 6);
		drain_products();

		// Phase two: the other way round.
		tx_idle_pct = 68;
		rx_idle_pct = 27;
		run_random(RAND_ITEMS / 3);
		drain_products();

		// Phase three: full rate both sides.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 6) - RAND_ITEMS / 3);
		drain_products();

		// Give the pipeline time to show any stray product.
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("product_low: %0d expected products never arrived", sb.pending());
			sb.errors++;
		end

		$display("Run covered %0d operand pairs (directed extremes, then random) under",
			sb.noted);
		$display("heavy-stall, heavy-gap and full-rate phases; %0d products compared.",
			sb.checked);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
